/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the interpolator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define KSPI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("kspi: assertion failed");

// Same-cycle implication
`define KSPI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kspi: implication failed");

// Next-cycle implication
`define KSPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kspi: next-cycle implication failed");

`endif

/* hw/rtl/kspi_pkg.sv */
// Package for the 3-D k-space sinc interpolator: widths, codes, word types.
// No dependencies; used by every module of the block but kspi_ram.
package kspi_pkg;

   // parameter defaults
   localparam int MAX_X_DEF  = 32;
   localparam int MAX_Y_DEF  = 32;
   localparam int MAX_Z_DEF  = 32;
   localparam int RADIUS_DEF = 4;
   localparam int PHASES_DEF = 64;

   // field and datapath widths
   localparam int SZ_W     = 6;
   localparam int RES_W    = 16;
   localparam int K_W      = 32;
   localparam int SAMP_W   = 16;
   localparam int OUT_W    = 32;
   localparam int ENTRY_W  = 2 * SAMP_W;
   localparam int WGT_W    = 17;
   localparam int IDX_W    = 8;
   localparam int YZ_W     = 12;
   localparam int ACC_W    = 56;
   localparam int PROD1_W  = K_W + RES_W + 1;
   localparam int POS_W    = 58;
   localparam int FRAC_SH  = 15;
   localparam int POS_FRAC = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // reset values of the registers
   localparam logic [SZ_W-1:0]  SIZE_RST = 6'd32;
   localparam logic [RES_W-1:0] RES_RST  = 16'd4096;

   // pi in Q2.30 for the weight table
   localparam longint PI_Q30 = 64'sd3373259426;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_X = 3'd0,
      CSR_SIZE_Y = 3'd1,
      CSR_SIZE_Z = 3'd2,
      CSR_RES_X  = 3'd3,
      CSR_RES_Y  = 3'd4,
      CSR_RES_Z  = 3'd5
   } kspi_csr_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } kspi_cmd_type;

   typedef struct packed {
      logic                     cmd;
      logic [14:0]              sample_address;
      logic signed [SAMP_W-1:0] sample_re;
      logic signed [SAMP_W-1:0] sample_im;
      logic signed [K_W-1:0]    k_x;
      logic signed [K_W-1:0]    k_y;
      logic signed [K_W-1:0]    k_z;
   } kspi_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] result_re;
      logic signed [OUT_W-1:0] result_im;
      logic                    outside;
   } kspi_rsp_type;

   // sequencer to tap engine
   typedef struct packed {
      logic            start;
      logic [SZ_W-1:0] base_x;
      logic [SZ_W-1:0] base_y;
      logic [SZ_W-1:0] base_z;
      logic [SZ_W-1:0] size_x;
      logic [SZ_W-1:0] size_y;
      logic [SZ_W-1:0] size_z;
   } kspi_mac_ctrl_type;

   // tap engine to sequencer
   typedef struct packed {
      logic                    done;
      logic signed [OUT_W-1:0] sum_re;
      logic signed [OUT_W-1:0] sum_im;
   } kspi_mac_stat_type;

endpackage

/* hw/rtl/sinc_kspace_interpolator_3d.sv */
// Top level of the 3-D k-space windowed-sinc interpolator: registers, query
// setup sequencer, volume RAM, result register. Depends on kspi_pkg, kspi_ram,
// kspi_mac and assert_macros.svh.
//
//  channel | ports                         | carries
//  --------+-------------------------------+---------------------------------
//  request | req_valid/req_ready/req_word  | volume write or k-space query
//  result  | rsp_valid/rsp_ready/rsp_word  | one word per query, none per write
//  config  | csr_we/csr_index/csr_wdata    | sizes and resolutions, no read-back
//
// A query holds the input through setup (three axes in turn, each via KRES, SCALE
// and CHECK on shared multipliers), a launch, each tap of the 9x9x9 cube in turn
// through the single volume read port, the pipeline tail and the result load.
// Outside queries skip launch and taps. Results are valid the cycle after load.
// Reset clears control and registers only; the volume is undefined until written.
// A pending result waits in the output register while the next word is taken; a
// query that finishes before that result drains holds in its load cycle.
`include "assert_macros.svh"
module sinc_kspace_interpolator_3d #(
   parameter int MAX_X  = kspi_pkg::MAX_X_DEF,
   parameter int MAX_Y  = kspi_pkg::MAX_Y_DEF,
   parameter int MAX_Z  = kspi_pkg::MAX_Z_DEF,
   parameter int RADIUS = kspi_pkg::RADIUS_DEF,
   parameter int PHASES = kspi_pkg::PHASES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  kspi_pkg::kspi_req_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output kspi_pkg::kspi_rsp_type              rsp_word,
   input  logic                                csr_we,
   input  logic [kspi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kspi_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = $clog2(PHASES);
   localparam int SZ = kspi_pkg::SZ_W;
   localparam int POS_W = kspi_pkg::POS_W;
   localparam logic [1:0] AX_LAST = 2'd2;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_KRES   = 7'b0000010,
      ST_SCALE  = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_LAUNCH = 7'b0010000,
      ST_RUN    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [SZ-1:0]             size_x_ff, size_y_ff, size_z_ff;
   logic [kspi_pkg::RES_W-1:0] res_x_ff, res_y_ff, res_z_ff;
   logic [SZ-1:0]             sx, sy, sz;

   logic signed [kspi_pkg::K_W-1:0] k_ff [3];
   logic [1:0]                axis_ff;
   logic signed [kspi_pkg::K_W-1:0] k_sel;
   logic [kspi_pkg::RES_W-1:0] res_sel;
   logic [SZ-1:0]             size_sel;
   logic signed [kspi_pkg::PROD1_W-1:0] prod1_ff;
   logic signed [POS_W-1:0]   pos_ff, pos_in, half_sh, pos_lim;
   logic                      out_now, outside_ff;
   logic [43:0]               ph_full;
   logic [SZ-1:0]             base_ff [3];
   logic [PW-1:0]             phase_ff [3];

   logic                      req_acc, wr_en, query_acc;
   logic [31:0]               wr_addr_full;

   kspi_pkg::kspi_mac_ctrl_type mac_ctrl;
   kspi_pkg::kspi_mac_stat_type mac_stat;
   logic [AW-1:0]             ram_raddr;
   logic [kspi_pkg::ENTRY_W-1:0] ram_rdata;

   logic                      rsp_valid_ff;
   kspi_pkg::kspi_rsp_type    rsp_word_ff;
   logic                      rsp_load;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= kspi_pkg::SIZE_RST;
         size_y_ff <= kspi_pkg::SIZE_RST;
         size_z_ff <= kspi_pkg::SIZE_RST;
         res_x_ff  <= kspi_pkg::RES_RST;
         res_y_ff  <= kspi_pkg::RES_RST;
         res_z_ff  <= kspi_pkg::RES_RST;
      end else if (csr_we) begin
         unique case (kspi_pkg::kspi_csr_type'(csr_index))
            kspi_pkg::CSR_SIZE_X: size_x_ff <= csr_wdata[SZ-1:0];
            kspi_pkg::CSR_SIZE_Y: size_y_ff <= csr_wdata[SZ-1:0];
            kspi_pkg::CSR_SIZE_Z: size_z_ff <= csr_wdata[SZ-1:0];
            kspi_pkg::CSR_RES_X:  res_x_ff  <= csr_wdata;
            kspi_pkg::CSR_RES_Y:  res_y_ff  <= csr_wdata;
            kspi_pkg::CSR_RES_Z:  res_z_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sizes limited to the volume
   assign sx = (32'(size_x_ff) > MAX_X) ? SZ'(MAX_X) : size_x_ff;
   assign sy = (32'(size_y_ff) > MAX_Y) ? SZ'(MAX_Y) : size_y_ff;
   assign sz = (32'(size_z_ff) > MAX_Z) ? SZ'(MAX_Z) : size_z_ff;

   // request handshake and volume writes
   assign req_ready    = (state_ff == ST_IDLE);
   assign req_acc      = req_valid && req_ready;
   assign query_acc    = req_acc && (req_word.cmd == kspi_pkg::CMD_QUERY);
   assign wr_addr_full = 32'(req_word.sample_address);
   assign wr_en        = req_acc && (req_word.cmd == kspi_pkg::CMD_WRITE) &&
                         (wr_addr_full < 32'(DEPTH));

   kspi_ram #(.WIDTH(kspi_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr_full[AW-1:0]),
      .wdata ({req_word.sample_re, req_word.sample_im}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // axis operand select
   always_comb begin
      unique case (axis_ff)
         2'd0: begin
            k_sel = k_ff[0]; res_sel = res_x_ff; size_sel = sx;
         end
         2'd1: begin
            k_sel = k_ff[1]; res_sel = res_y_ff; size_sel = sy;
         end
         default: begin
            k_sel = k_ff[2]; res_sel = res_z_ff; size_sel = sz;
         end
      endcase
   end

   // position = k*res*size + floor(size/2), 32 fraction bits
   always_comb begin
      half_sh = POS_W'(size_sel[SZ-1:1]) << kspi_pkg::POS_FRAC;
      pos_lim = POS_W'(size_sel) << kspi_pkg::POS_FRAC;
      pos_in  = prod1_ff * $signed({1'b0, size_sel}) + half_sh;
      out_now = (pos_ff < 0) || (pos_ff >= pos_lim);
      ph_full = 44'(pos_ff[kspi_pkg::POS_FRAC-1:0]) * 44'(PHASES);
   end

   // setup datapath
   always_ff @(posedge clock) begin
      if (query_acc) begin
         k_ff[0]    <= req_word.k_x;
         k_ff[1]    <= req_word.k_y;
         k_ff[2]    <= req_word.k_z;
         axis_ff    <= 2'd0;
         outside_ff <= 1'b0;
      end else if (state_ff == ST_CHECK) begin
         outside_ff        <= outside_ff | out_now;
         base_ff[axis_ff]  <= pos_ff[kspi_pkg::POS_FRAC +: SZ];
         phase_ff[axis_ff] <= ph_full[kspi_pkg::POS_FRAC +: PW];
         axis_ff           <= axis_ff + 1'b1;
      end
      if (state_ff == ST_KRES) begin
         prod1_ff <= k_sel * $signed({1'b0, res_sel});
      end
      if (state_ff == ST_SCALE) begin
         pos_ff <= pos_in;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (query_acc) state_in = ST_KRES;
         ST_KRES:   state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (axis_ff != AX_LAST) begin
               state_in = ST_KRES;
            end else if (outside_ff || out_now) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: state_in = ST_RUN;
         ST_RUN:    if (mac_stat.done) state_in = ST_DONE;
         ST_DONE:   if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // tap engine
   assign mac_ctrl.start  = (state_ff == ST_LAUNCH);
   assign mac_ctrl.base_x = base_ff[0];
   assign mac_ctrl.base_y = base_ff[1];
   assign mac_ctrl.base_z = base_ff[2];
   assign mac_ctrl.size_x = sx;
   assign mac_ctrl.size_y = sy;
   assign mac_ctrl.size_z = sz;

   kspi_mac #(
      .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z),
      .RADIUS(RADIUS), .PHASES(PHASES)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .phase_x   (phase_ff[0]),
      .phase_y   (phase_ff[1]),
      .phase_z   (phase_ff[2]),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .stat      (mac_stat)
   );

   // result register
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_word_ff.outside   <= outside_ff;
         rsp_word_ff.result_re <= outside_ff ? '0 : mac_stat.sum_re;
         rsp_word_ff.result_im <= outside_ff ? '0 : mac_stat.sum_im;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `KSPI_ASSERT_IMPL(a_done_in_run, clock, reset, mac_stat.done, state_ff == ST_RUN)
   `KSPI_ASSERT_IMPL(a_outside_zero, clock, reset, rsp_valid && rsp_word.outside,
                     (rsp_word.result_re == 0) && (rsp_word.result_im == 0))
   `KSPI_ASSERT_NEXT(a_query_setup, clock, reset, query_acc, state_ff == ST_KRES)

endmodule

/* hw/rtl/kspi_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module kspi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/kspi_wrom.sv */
// Sinc weight table (taps x phases, Q1.15) built at elaboration, column select.
// Depends on kspi_pkg.
module kspi_wrom #(
   parameter int RADIUS = kspi_pkg::RADIUS_DEF,
   parameter int PHASES = kspi_pkg::PHASES_DEF,
   localparam int TAPS = 2 * RADIUS + 1,
   localparam int PW = $clog2(PHASES)
) (
   input  logic [PW-1:0]                     phase_x,
   input  logic [PW-1:0]                     phase_y,
   input  logic [PW-1:0]                     phase_z,
   output logic signed [kspi_pkg::WGT_W-1:0] col_x [TAPS],
   output logic signed [kspi_pkg::WGT_W-1:0] col_y [TAPS],
   output logic signed [kspi_pkg::WGT_W-1:0] col_z [TAPS]
);

   logic signed [kspi_pkg::WGT_W-1:0] tbl [TAPS][PHASES];

   // each entry: sin(pi*p/P) from a 15th-order series, then divided by pi*offset
   for (genvar gd = 0; gd < TAPS; gd++) begin : g_tap
      for (genvar gp = 0; gp < PHASES; gp++) begin : g_ph
         localparam longint D   = longint'(gd) - longint'(RADIUS);
         localparam longint Q   = (2 * gp > PHASES) ? longint'(PHASES - gp) : longint'(gp);
         localparam longint X   = (kspi_pkg::PI_Q30 * Q) / PHASES;
         localparam longint X2  = (X * X) >> 30;
         localparam longint T1  = ((X * X2) >> 30) / 6;
         localparam longint T2  = ((T1 * X2) >> 30) / 20;
         localparam longint T3  = ((T2 * X2) >> 30) / 42;
         localparam longint T4  = ((T3 * X2) >> 30) / 72;
         localparam longint T5  = ((T4 * X2) >> 30) / 110;
         localparam longint T6  = ((T5 * X2) >> 30) / 156;
         localparam longint T7  = ((T6 * X2) >> 30) / 210;
         localparam longint SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7;
         localparam longint SN  = (SUM < 0) ? 64'sd0 : SUM;
         localparam longint OFF = D * PHASES - longint'(gp);
         localparam longint AOFF = (OFF < 0) ? -OFF : OFF;
         localparam longint DEN = kspi_pkg::PI_Q30 * AOFF;
         localparam longint DEN_S = (DEN == 0) ? 64'sd1 : DEN;
         localparam longint NUM = (SN * PHASES) << 15;
         localparam longint MAG = (NUM + DEN_S / 2) / DEN_S;
         localparam bit     ODD = (D & 1) != 0;
         localparam bit     POS = OFF > 0;
         localparam longint WV  = (gp == 0) ? ((D == 0) ? 64'sd32768 : 64'sd0) :
                                  ((ODD == POS) ? MAG : -MAG);
         assign tbl[gd][gp] = kspi_pkg::WGT_W'(WV);
      end
   end

   // one column per axis, phase held for the whole word
   always_comb begin
      for (int d = 0; d < TAPS; d++) begin
         col_x[d] = tbl[d][phase_x];
         col_y[d] = tbl[d][phase_y];
         col_z[d] = tbl[d][phase_z];
      end
   end

endmodule

/* hw/rtl/kspi_mac.sv */
// Tap engine: walks the taps cube, reads one entry per cycle, weights and sums.
// Depends on kspi_pkg, kspi_wrom and assert_macros.svh.
`include "assert_macros.svh"
module kspi_mac #(
   parameter int MAX_X  = kspi_pkg::MAX_X_DEF,
   parameter int MAX_Y  = kspi_pkg::MAX_Y_DEF,
   parameter int MAX_Z  = kspi_pkg::MAX_Z_DEF,
   parameter int RADIUS = kspi_pkg::RADIUS_DEF,
   parameter int PHASES = kspi_pkg::PHASES_DEF,
   localparam int PW = $clog2(PHASES),
   localparam int DEPTH = MAX_X * MAX_Y * MAX_Z,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  kspi_pkg::kspi_mac_ctrl_type     ctrl,
   input  logic [PW-1:0]                   phase_x,
   input  logic [PW-1:0]                   phase_y,
   input  logic [PW-1:0]                   phase_z,
   output logic [AW-1:0]                   ram_raddr,
   input  logic [kspi_pkg::ENTRY_W-1:0]    ram_rdata,
   output kspi_pkg::kspi_mac_stat_type     stat
);

   localparam int TAPS  = 2 * RADIUS + 1;
   localparam int TW    = $clog2(TAPS);
   localparam int IW    = kspi_pkg::IDX_W;
   localparam int WW    = kspi_pkg::WGT_W;
   localparam int ACC_W = kspi_pkg::ACC_W;
   localparam int SW    = kspi_pkg::SAMP_W;
   localparam logic [TW-1:0] T_LAST = TW'(TAPS - 1);
   localparam logic signed [ACC_W-1:0] ACC_HALF = 56'sd16384;
   localparam logic signed [ACC_W-1:0] SAT_MAX  = 56'sd2147483647;
   localparam logic signed [ACC_W-1:0] SAT_MIN  = -56'sd2147483648;

   logic signed [WW-1:0] col_x [TAPS];
   logic signed [WW-1:0] col_y [TAPS];
   logic signed [WW-1:0] col_z [TAPS];
   logic signed [WW-1:0] colx_ff [TAPS];
   logic signed [WW-1:0] coly_ff [TAPS];
   logic signed [WW-1:0] colz_ff [TAPS];

   logic          run_ff;
   logic [TW-1:0] ta_ff, tb_ff, tc_ff;
   logic          t_last;

   logic signed [IW-1:0] xi_in, yi_in, zi_in;
   logic                 vld_in;
   logic [kspi_pkg::YZ_W-1:0] yz_in;

   logic                 live1_ff, last1_ff, vld1_ff;
   logic signed [IW-1:0] xi1_ff;
   logic [kspi_pkg::YZ_W-1:0] yz1_ff;
   logic [TW-1:0]        ta1_ff, tb1_ff, tc1_ff;
   logic [31:0]          addr_full;

   logic                 live2_ff, last2_ff, vld2_ff;
   logic signed [2*WW-1:0] wprod2_ff;
   logic signed [WW-1:0] wz2_ff;

   logic signed [2*WW-1:0] wxy_full;
   logic signed [19:0]   wxy;
   logic                 live3_ff, last3_ff, vld3_ff;
   logic signed [36:0]   wp3_ff;
   logic [kspi_pkg::ENTRY_W-1:0] data3_ff;

   logic signed [36:0]   w_full;
   logic signed [21:0]   w;
   logic                 live4_ff, last4_ff, vld4_ff;
   logic signed [37:0]   pre_re4_ff, pre_im4_ff;

   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff;
   logic                    done_ff;

   function automatic logic signed [kspi_pkg::OUT_W-1:0] sat_round(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0] r;
      r = (acc + ACC_HALF) >>> kspi_pkg::FRAC_SH;
      if (r > SAT_MAX) begin
         r = SAT_MAX;
      end else if (r < SAT_MIN) begin
         r = SAT_MIN;
      end
      return r[kspi_pkg::OUT_W-1:0];
   endfunction

   kspi_wrom #(.RADIUS(RADIUS), .PHASES(PHASES)) u_wrom (
      .phase_x (phase_x),
      .phase_y (phase_y),
      .phase_z (phase_z),
      .col_x   (col_x),
      .col_y   (col_y),
      .col_z   (col_z)
   );

   // weight columns latched at start
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         colx_ff <= col_x;
         coly_ff <= col_y;
         colz_ff <= col_z;
      end
   end

   // tap counters, z fastest
   assign t_last = (ta_ff == T_LAST) && (tb_ff == T_LAST) && (tc_ff == T_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         ta_ff  <= '0;
         tb_ff  <= '0;
         tc_ff  <= '0;
      end else if (ctrl.start) begin
         run_ff <= 1'b1;
         ta_ff  <= '0;
         tb_ff  <= '0;
         tc_ff  <= '0;
      end else if (run_ff) begin
         if (t_last) begin
            run_ff <= 1'b0;
         end
         if (tc_ff == T_LAST) begin
            tc_ff <= '0;
            if (tb_ff == T_LAST) begin
               tb_ff <= '0;
               ta_ff <= ta_ff + 1'b1;
            end else begin
               tb_ff <= tb_ff + 1'b1;
            end
         end else begin
            tc_ff <= tc_ff + 1'b1;
         end
      end
   end

   // stage 1: neighbor indices, range check, partial address
   always_comb begin
      xi_in  = IW'(int'(ctrl.base_x) + int'(ta_ff) - RADIUS);
      yi_in  = IW'(int'(ctrl.base_y) + int'(tb_ff) - RADIUS);
      zi_in  = IW'(int'(ctrl.base_z) + int'(tc_ff) - RADIUS);
      vld_in = (xi_in >= 0) && (xi_in < $signed({2'b00, ctrl.size_x})) &&
               (yi_in >= 0) && (yi_in < $signed({2'b00, ctrl.size_y})) &&
               (zi_in >= 0) && (zi_in < $signed({2'b00, ctrl.size_z}));
      yz_in  = kspi_pkg::YZ_W'(yi_in[IW-2:0]) +
               kspi_pkg::YZ_W'(ctrl.size_y) * kspi_pkg::YZ_W'(zi_in[IW-2:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live1_ff <= 1'b0;
      end else begin
         live1_ff <= run_ff;
      end
      last1_ff <= t_last;
      vld1_ff  <= vld_in;
      xi1_ff   <= xi_in;
      yz1_ff   <= yz_in;
      ta1_ff   <= ta_ff;
      tb1_ff   <= tb_ff;
      tc1_ff   <= tc_ff;
   end

   // stage 2: memory read, x by y weight
   assign addr_full = 32'(xi1_ff[IW-2:0]) + 32'(ctrl.size_x) * 32'(yz1_ff);
   assign ram_raddr = addr_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         live2_ff <= 1'b0;
      end else begin
         live2_ff <= live1_ff;
      end
      last2_ff  <= last1_ff;
      vld2_ff   <= vld1_ff;
      wprod2_ff <= colx_ff[ta1_ff] * coly_ff[tb1_ff];
      wz2_ff    <= colz_ff[tc1_ff];
   end

   // stage 3: round, times z weight
   assign wxy_full = (wprod2_ff + 34'sd16384) >>> kspi_pkg::FRAC_SH;
   assign wxy      = wxy_full[19:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         live3_ff <= 1'b0;
      end else begin
         live3_ff <= live2_ff;
      end
      last3_ff <= last2_ff;
      vld3_ff  <= vld2_ff;
      wp3_ff   <= wxy * wz2_ff;
      data3_ff <= ram_rdata;
   end

   // stage 4: round, complex sample times weight
   assign w_full = (wp3_ff + 37'sd16384) >>> kspi_pkg::FRAC_SH;
   assign w      = w_full[21:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         live4_ff <= 1'b0;
      end else begin
         live4_ff <= live3_ff;
      end
      last4_ff   <= last3_ff;
      vld4_ff    <= vld3_ff;
      pre_re4_ff <= $signed(data3_ff[2*SW-1:SW]) * w;
      pre_im4_ff <= $signed(data3_ff[SW-1:0]) * w;
   end

   // accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= live4_ff && last4_ff;
      end
      if (ctrl.start) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (live4_ff && vld4_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(pre_re4_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(pre_im4_ff);
      end
   end

   assign stat.done   = done_ff;
   assign stat.sum_re = sat_round(acc_re_ff);
   assign stat.sum_im = sat_round(acc_im_ff);

   `KSPI_ASSERT_IMPL(a_start_idle, clock, reset, ctrl.start, !run_ff && !live4_ff)
   `KSPI_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff)

endmodule

/* dv/sinc_kspace_interpolator_3d_tb.sv */
// Self-checking testbench for sinc_kspace_interpolator_3d: volume writes and
// k-space queries under several size/resolution settings, with random stalls.
// Depends on kspi_pkg and the interpolator RTL.
module sinc_kspace_interpolator_3d_tb;
   import kspi_pkg::*;

   localparam int NTAP       = 2 * RADIUS_DEF + 1;
   localparam int NPHASE     = PHASES_DEF;
   localparam int VOL_DEPTH  = MAX_X_DEF * MAX_Y_DEF * MAX_Z_DEF;
   localparam int DRAIN_WAIT = 800;
   localparam int CYCLE_CAP  = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   kspi_req_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   kspi_rsp_type rsp_word;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sinc_kspace_interpolator_3d i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the block state
   shortint vol_re [0:VOL_DEPTH-1];
   shortint vol_im [0:VOL_DEPTH-1];
   bit written [0:VOL_DEPTH-1];
   int sinc_tab [0:NTAP-1][0:NPHASE-1];
   int size_x = 32, size_y = 32, size_z = 32;
   int res_x = 4096, res_y = 4096, res_z = 4096;

   kspi_req_type pending_words [$];
   kspi_rsp_type expected_rsps [$];
   bit no_gaps = 1'b0;
   int errors = 0, n_writes = 0, n_queries = 0, n_outside = 0, cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // sin(pi*p/PHASES) in Q2.30, odd power series
   function automatic longint unsigned sine_q30(int p);
      longint unsigned x, x2, term, pi_u;
      longint acc;
      int q;
      pi_u = longint'(PI_Q30);
      q = p;
      if (2 * q > NPHASE) q = NPHASE - q;
      x = pi_u * longint'(q) / longint'(NPHASE);
      x2 = (x * x) >> 30;
      acc = longint'(x);
      term = x;
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) acc -= longint'(term);
         else acc += longint'(term);
      end
      return (acc < 0) ? 0 : longint'(acc);
   endfunction

   // Q1.15 sinc weight for tap offset d at phase p
   function automatic int sinc_q15(int d, int p);
      longint off;
      longint unsigned num, den, mag;
      bit odd, pos;
      if (p == 0) return (d == 0) ? 32768 : 0;
      off = longint'(d) * NPHASE - p;
      den = longint'(PI_Q30) * longint'((off < 0) ? -off : off);
      num = (sine_q30(p) * longint'(NPHASE)) << 15;
      mag = (num + den / 2) / den;
      odd = (d % 2) != 0;
      pos = off > 0;
      return (odd == pos) ? int'(mag) : -int'(mag);
   endfunction

   function automatic int clip_size(int s, int mx);
      return (s > mx) ? mx : s;
   endfunction

   // axis index with 32 fraction bits; returns 1 when outside the volume
   function automatic bit locate_axis(longint k, int res, int sz,
                                      output int base, output int phase);
      longint pos, frac;
      base = 0;
      phase = 0;
      pos = k * res * sz + (longint'(sz >> 1) <<< 32);
      if (pos < 0 || pos >= (longint'(sz) <<< 32)) return 1'b1;
      base = int'(pos >>> 32);
      frac = pos & 64'hFFFF_FFFF;
      phase = int'((frac * NPHASE) >>> 32);
      return 1'b0;
   endfunction

   function automatic longint round_q15(longint v);
      return (v + 16384) >>> 15;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // interpolated value of one query under the current settings
   function automatic kspi_rsp_type interpolate(kspi_req_type w);
      kspi_rsp_type r;
      int sx, sy, sz, bx, by, bz, px, py, pz, xi, yi, zi, addr;
      longint acc_re, acc_im, wxy, wt;
      bit out_x, out_y, out_z;
      sx = clip_size(size_x, MAX_X_DEF);
      sy = clip_size(size_y, MAX_Y_DEF);
      sz = clip_size(size_z, MAX_Z_DEF);
      r = '0;
      out_x = locate_axis(longint'(w.k_x), res_x, sx, bx, px);
      out_y = locate_axis(longint'(w.k_y), res_y, sy, by, py);
      out_z = locate_axis(longint'(w.k_z), res_z, sz, bz, pz);
      if (out_x || out_y || out_z) begin
         r.outside = 1'b1;
         return r;
      end
      acc_re = 0;
      acc_im = 0;
      for (int a = 0; a < NTAP; a++) begin
         xi = bx + a - RADIUS_DEF;
         if (xi < 0 || xi >= sx) continue;
         for (int b = 0; b < NTAP; b++) begin
            yi = by + b - RADIUS_DEF;
            if (yi < 0 || yi >= sy) continue;
            wxy = round_q15(longint'(sinc_tab[a][px]) * sinc_tab[b][py]);
            for (int c = 0; c < NTAP; c++) begin
               zi = bz + c - RADIUS_DEF;
               if (zi < 0 || zi >= sz) continue;
               wt = round_q15(wxy * sinc_tab[c][pz]);
               addr = xi + sx * (yi + sy * zi);
               acc_re += longint'(vol_re[addr]) * wt;
               acc_im += longint'(vol_im[addr]) * wt;
            end
         end
      end
      r.result_re = 32'(sat32(round_q15(acc_re)));
      r.result_im = 32'(sat32(round_q15(acc_im)));
      return r;
   endfunction

   // update the shadow volume or queue the expected result of an accepted word
   task automatic absorb_word(kspi_req_type w);
      if (w.cmd == CMD_WRITE) begin
         vol_re[w.sample_address] = w.sample_re;
         vol_im[w.sample_address] = w.sample_im;
         n_writes++;
      end else begin
         expected_rsps.push_back(interpolate(w));
         n_queries++;
      end
   endtask

   // request driver
   int gap_left = 0;
   always @(posedge clock) begin
      bit hold;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         hold = req_valid && !req_ready;
         if (req_valid && req_ready) absorb_word(req_word);
         if (hold) begin
            req_valid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_word <= pending_words.pop_front();
            req_valid <= 1'b1;
            gap_left = no_gaps ? 0 : $urandom_range(0, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor and checker
   int stall_left = 0;
   always @(posedge clock) begin
      kspi_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result word re=%0d im=%0d outside=%0b",
                      rsp_word.result_re, rsp_word.result_im, rsp_word.outside);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_word.outside !== want.outside) begin
                  $error("outside: expected %0b, got %0b", want.outside, rsp_word.outside);
                  errors++;
               end
               if (rsp_word.result_re !== want.result_re) begin
                  $error("result_re: expected %0d, got %0d", want.result_re,
                         rsp_word.result_re);
                  errors++;
               end
               if (rsp_word.result_im !== want.result_im) begin
                  $error("result_im: expected %0d, got %0d", want.result_im,
                         rsp_word.result_im);
                  errors++;
               end
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, 17);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   function automatic kspi_req_type write_word(int addr, int re, int im);
      kspi_req_type w;
      w.cmd = CMD_WRITE;
      w.sample_address = 15'(addr);
      w.sample_re = 16'(re);
      w.sample_im = 16'(im);
      w.k_x = $urandom;
      w.k_y = $urandom;
      w.k_z = $urandom;
      return w;
   endfunction

   task automatic post_write(int addr, int re, int im);
      written[addr] = 1'b1;
      pending_words.push_back(write_word(addr, re, im));
   endtask

   // queue a query, first writing any neighbor entry not yet written
   task automatic post_query(int kx, int ky, int kz);
      kspi_req_type w;
      int sx, sy, sz, bx, by, bz, px, py, pz, xi, yi, zi, addr;
      bit ox, oy, oz;
      sx = clip_size(size_x, MAX_X_DEF);
      sy = clip_size(size_y, MAX_Y_DEF);
      sz = clip_size(size_z, MAX_Z_DEF);
      ox = locate_axis(longint'(kx), res_x, sx, bx, px);
      oy = locate_axis(longint'(ky), res_y, sy, by, py);
      oz = locate_axis(longint'(kz), res_z, sz, bz, pz);
      if (!(ox || oy || oz)) begin
         for (int c = -RADIUS_DEF; c <= RADIUS_DEF; c++)
            for (int b = -RADIUS_DEF; b <= RADIUS_DEF; b++)
               for (int a = -RADIUS_DEF; a <= RADIUS_DEF; a++) begin
                  xi = bx + a;
                  yi = by + b;
                  zi = bz + c;
                  if (xi < 0 || xi >= sx || yi < 0 || yi >= sy || zi < 0 || zi >= sz)
                     continue;
                  addr = xi + sx * (yi + sy * zi);
                  if (!written[addr]) post_write(addr, $urandom, $urandom);
               end
      end
      w.cmd = CMD_QUERY;
      w.sample_address = 15'($urandom);
      w.sample_re = 16'($urandom);
      w.sample_im = 16'($urandom);
      w.k_x = kx;
      w.k_y = ky;
      w.k_z = kz;
      pending_words.push_back(w);
   endtask

   // k value that lands inside, on an edge, or anywhere on one axis
   function automatic int pick_k(int res, int sz_raw);
      longint t, denom, kk;
      int sz, pick;
      sz = clip_size(sz_raw, MAX_X_DEF);
      pick = $urandom_range(0, 9);
      denom = longint'(res) * sz;
      if (pick < 2 || denom == 0) return $urandom;
      if (pick == 2) begin
         case ($urandom_range(0, 3))
            0: t = 0;
            1: t = (longint'(sz) <<< 32) - 1;
            2: t = longint'(sz) <<< 32;
            default: t = -1;
         endcase
      end else begin
         t = (longint'($urandom_range(0, sz - 1)) <<< 32) | longint'($urandom);
      end
      kk = (t - (longint'(sz >> 1) <<< 32)) / denom;
      if (kk > 64'sd2147483647) kk = 64'sd2147483647;
      if (kk < -64'sd2147483648) kk = -64'sd2147483648;
      return int'(kk);
   endfunction

   task automatic csr_write(kspi_csr_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SIZE_X: size_x = int'(data[SZ_W-1:0]);
         CSR_SIZE_Y: size_y = int'(data[SZ_W-1:0]);
         CSR_SIZE_Z: size_z = int'(data[SZ_W-1:0]);
         CSR_RES_X:  res_x = int'(data);
         CSR_RES_Y:  res_y = int'(data);
         CSR_RES_Z:  res_z = int'(data);
         default: ;
      endcase
   endtask

   task automatic set_sizes(int sx, int sy, int sz, int rx, int ry, int rz);
      csr_write(CSR_SIZE_X, {10'($urandom_range(0, 1023)), 6'(sx)});
      csr_write(CSR_SIZE_Y, {10'($urandom_range(0, 1023)), 6'(sy)});
      csr_write(CSR_SIZE_Z, {10'($urandom_range(0, 1023)), 6'(sz)});
      csr_write(CSR_RES_X, 16'(rx));
      csr_write(CSR_RES_Y, 16'(ry));
      csr_write(CSR_RES_Z, 16'(rz));
   endtask

   // wait until every word is taken and every result checked, then drain
   task automatic wait_idle();
      @(negedge clock);
      while (pending_words.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic int rand_size();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(33, 63);
         default: return $urandom_range(1, 9);
      endcase
   endfunction

   function automatic int rand_res();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 65535;
         2: return 1;
         default: return $urandom_range(1, 65535);
      endcase
   endfunction

   initial begin
      int sx, sy, sz, rx, ry, rz, vol, sel;
      for (int d = 0; d < NTAP; d++)
         for (int p = 0; p < NPHASE; p++)
            sinc_tab[d][p] = sinc_q15(d - RADIUS_DEF, p);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, sample extremes, k extremes, corner neighborhood
      post_write(0, -32768, 32767);
      post_write(VOL_DEPTH - 1, 32767, -32768);
      post_write(1, 0, 0);
      post_query(32'h7FFF_FFFF, 0, 0);
      post_query(32'h8000_0000, 0, 0);
      post_query(0, 32'h7FFF_FFFF, 32'h8000_0000);
      post_query(-524288, -524288, -524288);
      post_query(-520192, -522240, -523264);
      wait_idle();

      for (int phase_no = 0; phase_no < 10; phase_no++) begin
         case (phase_no)
            0: begin sx = 1;  sy = 1;  sz = 1;  rx = 4096;  ry = 4096;  rz = 4096;  end
            1: begin sx = 0;  sy = 4;  sz = 4;  rx = 4096;  ry = 1;     rz = 65535; end
            2: begin sx = 40; sy = 3;  sz = 2;  rx = 0;     ry = 0;     rz = 0;     end
            3: begin sx = 9;  sy = 9;  sz = 3;  rx = 65535; ry = 65535; rz = 65535; end
            4: begin sx = 5;  sy = 63; sz = 1;  rx = 1;     ry = 1;     rz = 1;     end
            default: begin
               sx = rand_size(); sy = rand_size(); sz = rand_size();
               rx = rand_res();  ry = rand_res();  rz = rand_res();
            end
         endcase
         no_gaps = ($urandom_range(0, 3) == 0);
         set_sizes(sx, sy, sz, rx, ry, rz);
         vol = clip_size(size_x, MAX_X_DEF) * clip_size(size_y, MAX_Y_DEF) *
               clip_size(size_z, MAX_Z_DEF);
         for (int n = 0; n < 40; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 25)
               post_query(pick_k(res_x, size_x), pick_k(res_y, size_y),
                          pick_k(res_z, size_z));
            else if (sel < 35 || vol == 0)
               post_write($urandom_range(0, VOL_DEPTH - 1), $urandom, $urandom);
            else
               post_write($urandom_range(0, vol - 1), $urandom, $urandom);
         end
         wait_idle();
      end

      $display("covered %0d volume writes and %0d queries, %0d of them outside",
               n_writes, n_queries, n_outside);
      $display("across 11 size/resolution settings in %0d cycles", cycles);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // tally outside results as they are checked
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_word.outside) n_outside++;
   end

endmodule
